@@ rtl/core/smp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Substring match package
// Operation codes, byte widths and the control bundle that the top level
// broadcasts to every cell of the comparator row.
// ----------------------------------------------------------------------------
package smp_pkg;

  // Width of one pattern or text byte.
  localparam int unsigned SymW = 8;
  // Width of the reported start position.
  localparam int unsigned IdxW = 6;
  // Width of the operation field.
  localparam int unsigned OpW = 2;

  // Operation codes carried by an input beat.
  typedef enum logic [OpW-1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } op_e;

  // Shift and clear commands that every cell sees in the same cycle.
  typedef struct packed {
    logic clear;
    logic pat_shift;
    logic txt_shift;
  } cell_ctrl_t;

endpackage

@@ rtl/core/smp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Substring match channels
// Valid/ready channels for the command stream and the match results.
// ----------------------------------------------------------------------------
interface smp_in_if;
  logic                      valid;
  logic                      ready;
  logic [smp_pkg::OpW-1:0]   op;
  logic [smp_pkg::SymW-1:0]  symbol;

  modport source (output valid, output op, output symbol, input ready);
  modport sink   (input valid, input op, input symbol, output ready);
endinterface

interface smp_out_if;
  logic                      valid;
  logic                      ready;
  logic [smp_pkg::IdxW-1:0]  start_index;

  modport source (output valid, output start_index, input ready);
  modport sink   (input valid, input start_index, output ready);
endinterface

@@ rtl/core/smp_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Substring match cell
// One position of the comparator row. It holds one pattern byte and one text
// byte, each so many places back from the newest byte of its stream, and
// reports whether the two agree for positions inside the pattern.
// ----------------------------------------------------------------------------
module smp_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smp_pkg::cell_ctrl_t        ctrl_i,
  input  logic [smp_pkg::SymW-1:0]   pat_i,
  input  logic [smp_pkg::SymW-1:0]   txt_i,
  input  logic                       act_i,
  output logic [smp_pkg::SymW-1:0]   pat_o,
  output logic [smp_pkg::SymW-1:0]   txt_o,
  output logic                       act_o,
  output logic                       hit_o
);
  import smp_pkg::*;

  logic [SymW-1:0] pat_q;
  logic [SymW-1:0] txt_q;
  logic            act_q;

  // The active flag marks cells that lie inside the current pattern.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      act_q <= 1'b0;
    end else if (ctrl_i.pat_shift) begin
      act_q <= act_i;
    end
  end

  // Byte registers shift towards older positions as new bytes arrive.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_shift) begin
      pat_q <= pat_i;
    end
    if (ctrl_i.txt_shift) begin
      txt_q <= txt_i;
    end
  end

  assign pat_o = pat_q;
  assign txt_o = txt_q;
  assign act_o = act_q;

  // Cells outside the pattern never veto a match.
  assign hit_o = !act_q || (pat_q == txt_q);

endmodule

@@ rtl/core/substring_match_positions.sv @@
`timescale 1ns / 1ps
// A match on a text beat is compared once the comparator row has shifted and
// is offered on the output from the output register.
// After each stored text beat the row takes no new beat until the compare that
// follows the shift is done; clear and pattern beats start no compare.
// A result that waits on the output holds off the next input beat.
// Reset: counts and cell active flags clear at once; byte stores need no reset.
// ----------------------------------------------------------------------------
// Streaming substring search
// A row of MAX_LEN cells holds the pattern and the text, newest byte first.
// After each stored text byte every cell compares its pair, and the AND of all
// cells tells whether the pattern ends at the newest text byte.
// ----------------------------------------------------------------------------
module substring_match_positions #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smp_in_if.sink    in_i,
  smp_out_if.source out_o
);
  import smp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);

  logic [CntW-1:0]  plen_q, plen_d;
  logic [CntW-1:0]  tcnt_q, tcnt_d;
  logic             chk_q;
  logic             out_vld_q;
  logic [IdxW-1:0]  start_q;
  logic             acc;
  logic             found;
  logic             hit_all;
  logic [CntW-1:0]  start_full;
  cell_ctrl_t       ctrl;

  logic [SymW-1:0]  pat_c [MAX_LEN];
  logic [SymW-1:0]  txt_c [MAX_LEN];
  logic [MAX_LEN-1:0] act_c;
  logic [MAX_LEN-1:0] hit_c;

  // A new beat waits while a compare is pending or a result is stuck.
  assign in_i.ready = !chk_q && (!out_vld_q || out_o.ready);
  assign acc        = in_i.valid && in_i.ready;

  // Decode the accepted beat into row commands; full stores drop bytes.
  always_comb begin
    ctrl           = '0;
    plen_d         = plen_q;
    tcnt_d         = tcnt_q;
    if (acc) begin
      unique case (in_i.op)
        OP_CLEAR: begin
          ctrl.clear = 1'b1;
          plen_d     = '0;
          tcnt_d     = '0;
        end
        OP_PATTERN: begin
          if (plen_q != CntW'(MAX_LEN)) begin
            ctrl.pat_shift = 1'b1;
            plen_d         = plen_q + 1'b1;
          end
        end
        OP_TEXT: begin
          if (tcnt_q != CntW'(MAX_LEN)) begin
            ctrl.txt_shift = 1'b1;
            tcnt_d         = tcnt_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Comparator row: cell zero takes the incoming byte.
  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    logic [SymW-1:0] pat_in;
    logic [SymW-1:0] txt_in;
    logic            act_in;

    if (j == 0) begin : g_head
      assign pat_in = in_i.symbol;
      assign txt_in = in_i.symbol;
      assign act_in = 1'b1;
    end else begin : g_body
      assign pat_in = pat_c[j-1];
      assign txt_in = txt_c[j-1];
      assign act_in = act_c[j-1];
    end

    smp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .pat_i  (pat_in),
      .txt_i  (txt_in),
      .act_i  (act_in),
      .pat_o  (pat_c[j]),
      .txt_o  (txt_c[j]),
      .act_o  (act_c[j]),
      .hit_o  (hit_c[j])
    );
  end

  // A full match needs a non-empty pattern that fits in the text so far.
  assign hit_all    = &hit_c;
  assign found      = (plen_q != '0) && (tcnt_q >= plen_q) && hit_all;
  assign start_full = tcnt_q - plen_q;

  // Counters, compare flag and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q    <= '0;
      tcnt_q    <= '0;
      chk_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      plen_q <= plen_d;
      tcnt_q <= tcnt_d;
      chk_q  <= ctrl.txt_shift;
      if (chk_q) begin
        out_vld_q <= found;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // The start position is masked to the output width.
  always_ff @(posedge clk_i) begin
    if (chk_q) begin
      start_q <= IdxW'(start_full);
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.start_index = start_q;

endmodule
